[sv/aip_pkg.sv]
// ----------------------------------------------------------------------------
// aip_pkg: shared types and constants for the ASCII integer parser
// Character codes, parse phase encoding and the result beat layout.
// ----------------------------------------------------------------------------
`default_nettype none

package aip_pkg;

  // character codes
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  // base used when radix is zero
  localparam logic [5:0] DefaultBase = 6'd10;

  // saturation limits
  localparam logic [63:0] PosLimit = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NegLimit = 64'h8000_0000_0000_0000;

  // parse phase
  typedef enum logic [1:0] {
    PH_LEAD = 2'd0,  // skipping leading whitespace
    PH_BODY = 2'd1   // sign or digit seen
  } phase_t;

  // one result beat
  typedef struct packed {
    logic [63:0] value;
    logic [15:0] consumed;
    logic        no_digits;
    logic        overflow;
  } result_t;

endpackage

`default_nettype wire

[sv/aip_core.sv]
// ----------------------------------------------------------------------------
// aip_core: input register and parse state
// Holds one character beat, classifies it and updates the running number;
// on a terminating character it offers one result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module aip_core #(
  parameter int unsigned MAX_LENGTH = 65535
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire  [5:0]        radix,
  input  wire               in_valid,
  input  wire  [7:0]        in_ch,
  output logic              in_ready,
  output logic              res_valid,
  output aip_pkg::result_t  res,
  input  wire               res_ready
);

  localparam logic [15:0] CountCap =
      (MAX_LENGTH < 32'd65535) ? MAX_LENGTH[15:0] : 16'hFFFF;

  // input register
  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_ch_r;

  // parse state
  aip_pkg::phase_t phase_r, phase_nxt;
  logic        neg_r, neg_nxt;
  logic [63:0] mag_r, mag_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic        saw_r, saw_nxt;
  logic        ovf_r, ovf_nxt;

  logic [5:0]  base;
  logic [3:0]  digit;
  logic        is_ws, is_sign, is_digit, lead, s1_term, s1_fire;
  logic [69:0] prod;
  logic [63:0] limit;
  logic [15:0] cnt_inc;

  // character classification
  always_comb begin
    base     = (radix == 6'd0) ? aip_pkg::DefaultBase : radix;
    digit    = s1_ch_r[3:0];
    is_ws    = (s1_ch_r == aip_pkg::ChSpace) || (s1_ch_r == aip_pkg::ChTab) ||
               (s1_ch_r == aip_pkg::ChNl);
    is_sign  = (s1_ch_r == aip_pkg::ChMinus) || (s1_ch_r == aip_pkg::ChPlus);
    is_digit = (s1_ch_r >= aip_pkg::ChZero) && (s1_ch_r <= aip_pkg::ChNine) &&
               ({2'b00, digit} < base);
    case (phase_r)
      aip_pkg::PH_LEAD: lead = 1'b1;
      default:          lead = 1'b0;
    endcase
    s1_term  = !(lead && (is_ws || is_sign)) && !is_digit;
    s1_fire  = s1_valid_r && (!s1_term || res_ready);
    in_ready = !s1_valid_r || s1_fire;
  end

  // multiply-add and range check
  always_comb begin
    prod    = 70'(mag_r) * 70'(base) + 70'(digit);
    limit   = neg_r ? aip_pkg::NegLimit : aip_pkg::PosLimit;
    cnt_inc = (cnt_r < CountCap) ? cnt_r + 16'd1 : cnt_r;
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    cnt_nxt   = cnt_r;
    saw_nxt   = saw_r;
    ovf_nxt   = ovf_r;
    if (s1_fire) begin
      if (lead && is_ws) begin
        cnt_nxt = cnt_inc;
      end else if (lead && is_sign) begin
        neg_nxt   = (s1_ch_r == aip_pkg::ChMinus);
        cnt_nxt   = cnt_inc;
        phase_nxt = aip_pkg::PH_BODY;
      end else if (is_digit) begin
        if (!ovf_r) begin
          if (prod > {6'b0, limit}) ovf_nxt = 1'b1;
          else                      mag_nxt = prod[63:0];
        end
        saw_nxt   = 1'b1;
        cnt_nxt   = cnt_inc;
        phase_nxt = aip_pkg::PH_BODY;
      end else begin
        phase_nxt = aip_pkg::PH_LEAD;
        neg_nxt   = 1'b0;
        mag_nxt   = 64'd0;
        cnt_nxt   = 16'd0;
        saw_nxt   = 1'b0;
        ovf_nxt   = 1'b0;
      end
    end
  end

  // result beat
  always_comb begin
    res_valid = s1_valid_r && s1_term;
    if (!saw_r)      res.value = 64'd0;
    else if (ovf_r)  res.value = limit;
    else if (neg_r)  res.value = 64'd0 - mag_r;
    else             res.value = mag_r;
    res.consumed  = saw_r ? cnt_r : 16'd0;
    res.no_digits = !saw_r;
    res.overflow  = saw_r && ovf_r;
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ready) s1_valid_nxt = in_valid;
    else if (s1_fire) s1_valid_nxt = 1'b0;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      phase_r    <= aip_pkg::PH_LEAD;
      neg_r      <= 1'b0;
      mag_r      <= 64'd0;
      cnt_r      <= 16'd0;
      saw_r      <= 1'b0;
      ovf_r      <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      phase_r    <= phase_nxt;
      neg_r      <= neg_nxt;
      mag_r      <= mag_nxt;
      cnt_r      <= cnt_nxt;
      saw_r      <= saw_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

  // character register, no reset needed
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) s1_ch_r <= in_ch;
  end

endmodule

`default_nettype wire

[sv/aip_out_stage.sv]
// ----------------------------------------------------------------------------
// aip_out_stage: result register
// Holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module aip_out_stage (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               res_valid,
  input  aip_pkg::result_t  res,
  output logic              res_ready,
  output logic              out_valid,
  output aip_pkg::result_t  out_res,
  input  wire               out_ready
);

  logic             out_valid_r, out_valid_nxt;
  aip_pkg::result_t out_res_r;

  // room when empty or being drained this cycle
  always_comb begin
    res_ready     = !out_valid_r || out_ready;
    out_valid_nxt = res_ready ? res_valid : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) out_res_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

`default_nettype wire

[sv/ascii_integer_parser.sv]
// ----------------------------------------------------------------------------
// ascii_integer_parser: streaming strtol-style integer parser
// Input channel carries one character per beat (in_ch). Leading space, tab
// and newline are skipped, one optional sign is taken, then digits below
// the base in cfg radix (0 means ten) are accumulated. The first character
// that fits none of these ends the number and is not consumed; it yields
// one result beat (value, consumed, no_digits, overflow) and the parser
// starts over with the next character.
// Throughput: one character per cycle while no terminator waits for room
// in the result register, with a combinational multiply-add-compare loop
// on the magnitude register in the core. A terminating character is held
// in the core input register, then its result in the out_ result register.
// Reset (synchronous, active low) clears the parse state, empties both
// registers and sets radix to ten. When the receiver stalls, the result
// register holds; characters that do not end a number keep flowing, and a
// terminator waits in the input register until the result register frees.
// Write radix with cfg_we only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_integer_parser #(
  parameter int unsigned MAX_LENGTH = 65535
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire  [5:0]  cfg_wdata,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  in_ch,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [63:0] out_value,
  output logic [15:0] out_consumed,
  output logic        out_no_digits,
  output logic        out_overflow
);

  logic [5:0]       radix_r;
  logic             res_valid, res_ready;
  aip_pkg::result_t res, out_res;

  // radix register
  always_ff @(posedge clk) begin
    if (!rst_n)      radix_r <= aip_pkg::DefaultBase;
    else if (cfg_we) radix_r <= cfg_wdata;
  end

  aip_core #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .radix     (radix_r),
    .in_valid  (in_valid),
    .in_ch     (in_ch),
    .in_ready  (in_ready),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  aip_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_valid (out_valid),
    .out_res   (out_res),
    .out_ready (out_ready)
  );

  assign out_value     = out_res.value;
  assign out_consumed  = out_res.consumed;
  assign out_no_digits = out_res.no_digits;
  assign out_overflow  = out_res.overflow;

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // empty number carries zero value and zero count
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_no_digits |-> out_value == 64'd0 && out_consumed == 16'd0)
    else $error("empty number with nonzero value or count");

  // overflow only on a number that has digits
  a_ovf_digits: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_overflow |-> !out_no_digits)
    else $error("overflow flagged without digits");

  // a number with digits consumed at least one character
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_no_digits |-> out_consumed != 16'd0)
    else $error("digits seen but nothing consumed");

endmodule

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for ascii_integer_parser
// Streams characters into the parser, keeps a cycle-free copy of the parse
// state to predict each result beat, and compares every result field by
// field. Covers every radix class from zero to 63, whitespace and sign
// handling and overflow saturation in both directions, with random gaps
// and stalls on both channels.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam logic [15:0] LEN_CAP     = 16'hFFFF;
  localparam logic [7:0]  CH_NUL      = 8'h00;
  localparam logic [7:0]  CH_BANG     = 8'h21;
  localparam logic [7:0]  CH_HIGH     = 8'hFF;
  localparam int          IDLE_PCT    = 34;
  localparam int          LONG_HOLD   = 300;
  localparam int          DRAIN_WAIT  = 4;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [5:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_ch = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_value;
  logic [15:0] out_consumed;
  logic        out_no_digits;
  logic        out_overflow;

  ascii_integer_parser uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_ch        (in_ch),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value    (out_value),
    .out_consumed (out_consumed),
    .out_no_digits(out_no_digits),
    .out_overflow (out_overflow)
  );

  // text waiting to be sent, parse results waiting to come back
  logic [7:0]       char_q[$];
  aip_pkg::result_t parse_q[$];

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned chars_in = 0;
  int unsigned results_seen = 0;
  int unsigned queued = 0;

  // shadow parser state
  logic [5:0]      radix_m = aip_pkg::DefaultBase;
  aip_pkg::phase_t phase_m = aip_pkg::PH_LEAD;
  logic            neg_m = 1'b0;
  logic [63:0]     mag_m = '0;
  logic [15:0]     len_m = '0;
  logic            digit_m = 1'b0;
  logic            ovf_m = 1'b0;

  string limit_txt[4] = '{"9223372036854775807", "9223372036854775808",
                          "9223372036854775806", "18446744073709551616"};

  // no idling on either side within this window of beats
  logic calm;
  assign calm = (chars_in >= 800) && (chars_in < 1100);

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // shadow parser
  // --------------------------------------------------------------------------
  function automatic void bump_length();
    if (len_m < LEN_CAP) len_m++;
  endfunction

  task automatic parse_char(input logic [7:0] c, output bit emit,
                            output aip_pkg::result_t res);
    logic [63:0] base, d, lim;
    emit = 1'b0;
    res = '0;
    base = (radix_m == 6'd0) ? 64'(aip_pkg::DefaultBase) : 64'(radix_m);
    if (phase_m == aip_pkg::PH_LEAD) begin
      if (c == aip_pkg::ChSpace || c == aip_pkg::ChTab || c == aip_pkg::ChNl) begin
        bump_length();
        return;
      end
      if (c == aip_pkg::ChMinus || c == aip_pkg::ChPlus) begin
        neg_m = (c == aip_pkg::ChMinus);
        bump_length();
        phase_m = aip_pkg::PH_BODY;
        return;
      end
      phase_m = aip_pkg::PH_BODY;
    end
    if (c >= aip_pkg::ChZero && c <= aip_pkg::ChNine &&
        64'(c - aip_pkg::ChZero) < base) begin
      d = 64'(c - aip_pkg::ChZero);
      lim = neg_m ? aip_pkg::NegLimit : aip_pkg::PosLimit;
      // once saturated the magnitude freezes, digits still count
      if (!ovf_m) begin
        if (mag_m > (lim - d) / base) ovf_m = 1'b1;
        else mag_m = mag_m * base + d;
      end
      digit_m = 1'b1;
      bump_length();
      return;
    end
    // terminator: not consumed, emits and restarts
    emit = 1'b1;
    if (!digit_m) res.value = '0;
    else if (ovf_m) res.value = neg_m ? aip_pkg::NegLimit : aip_pkg::PosLimit;
    else res.value = neg_m ? (64'd0 - mag_m) : mag_m;
    res.consumed  = digit_m ? len_m : 16'd0;
    res.no_digits = !digit_m;
    res.overflow  = digit_m && ovf_m;
    phase_m = aip_pkg::PH_LEAD;
    neg_m   = 1'b0;
    mag_m   = '0;
    len_m   = '0;
    digit_m = 1'b0;
    ovf_m   = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // input driver: predicts on each accepted beat
  // --------------------------------------------------------------------------
  bit               emit_d;
  aip_pkg::result_t res_d;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        parse_char(in_ch, emit_d, res_d);
        if (emit_d) parse_q.push_back(res_d);
        chars_in++;
      end
      if (!in_valid || in_ready) begin
        if (char_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_ch    <= char_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver back-pressure, with one long hold-off so the parser backs up
  // --------------------------------------------------------------------------
  int  hold_left = 0;
  bit  long_hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!long_hold_done && results_seen >= 60) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // result monitor
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  aip_pkg::result_t want_r;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (parse_q.size() == 0) begin
        errors++;
        $display("%0t: result beat with none expected: expected nothing, actual value %0h",
                 $time, out_value);
      end else begin
        want_r = parse_q.pop_front();
        check_field("value", want_r.value, out_value);
        check_field("consumed", 64'(want_r.consumed), 64'(out_consumed));
        check_field("no_digits", 64'(want_r.no_digits), 64'(out_no_digits));
        check_field("overflow", 64'(want_r.overflow), 64'(out_overflow));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void push_char(input logic [7:0] c);
    char_q.push_back(c);
    queued++;
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endfunction

  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 2))
      0: return aip_pkg::ChSpace;
      1: return aip_pkg::ChTab;
      default: return aip_pkg::ChNl;
    endcase
  endfunction

  function automatic logic [7:0] pick_sign();
    return $urandom_range(0, 1) ? aip_pkg::ChMinus : aip_pkg::ChPlus;
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // mostly well-formed numbers, some broken sign sequences, some raw noise
  function automatic void queue_random_text(input int budget);
    int unsigned stop;
    int          kind, n;
    logic [63:0] big;
    stop = queued + budget;
    while (queued < stop) begin
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        n = $urandom_range(0, 3);
        repeat (n) push_char(pick_space());
        if ($urandom_range(0, 2) != 0) push_char(pick_sign());
        case ($urandom_range(0, 9))
          0, 1: begin
            big = {$urandom, $urandom};
            push_text($sformatf("%0d", big));
          end
          2: push_text(limit_txt[$urandom_range(0, 3)]);
          3: repeat ($urandom_range(20, 24))
               push_char(aip_pkg::ChZero + 8'($urandom_range(0, 9)));
          default: repeat ($urandom_range(0, 8))
               push_char(aip_pkg::ChZero + 8'($urandom_range(0, 9)));
        endcase
        push_char($urandom_range(0, 1) ? CH_NUL : any_byte());
      end else if (kind < 90) begin
        push_char(pick_sign());
        push_char($urandom_range(0, 1) ? pick_space() : pick_sign());
        push_char(CH_NUL);
      end else begin
        repeat ($urandom_range(1, 6)) push_char(any_byte());
      end
    end
  endfunction

  // wait until nothing is in flight; negedge keeps clear of driver updates
  task automatic wait_drained();
    do @(negedge clk);
    while (char_q.size() != 0 || in_valid || parse_q.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_radix(input logic [5:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we  <= 1'b0;
    radix_m = v;
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  logic [5:0] radix_plan[10] = '{6'd0, 6'd1, 6'd2, 6'd9, 6'd11, 6'd16,
                                 6'd36, 6'd37, 6'd63, 6'd10};

  initial begin
    // directed, at the reset radix of ten
    push_text("\t\n 7");
    push_char(CH_NUL);
    // second sign ends with no digits, then a fresh string
    push_text("-+3");
    push_char(CH_NUL);
    // whitespace after sign
    push_text("+ ");
    push_char(CH_NUL);
    push_text("-0");
    push_char(CH_BANG);
    push_char(CH_HIGH);
    push_text("09");
    push_char(CH_HIGH);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    queue_random_text(170);
    foreach (radix_plan[i]) begin
      write_radix(radix_plan[i]);
      queue_random_text(170);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
